FILE: rtl/core/rse_pkg.sv
// ----------------------------------------------------------------------------
// rse_pkg: shared types, constants and GF(256) helpers
// Item formats, configuration register indexes and the field multiplier
// used by the generator derivation and the division LFSR.
// ----------------------------------------------------------------------------
package rse_pkg;

  localparam int unsigned PcW      = 6;
  localparam int unsigned FpW      = 9;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [FpW-1:0] FIELD_POLY_RESET = 9'h11d;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PARITY_COUNT = 2'd0,
    CFG_FIELD_POLY   = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_parity;
    logic       last_out;
    logic       fault;
  } out_item_t;

  // One classified message byte on its way from the front to the back.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       fault;
  } q_entry_t;

  // Configuration state seen by the front and the back.
  typedef struct packed {
    logic [PcW-1:0] parity_count;
    logic [7:0]     red;
    logic           clear;
    logic           busy;
  } rse_ctrl_t;

  // Multiplication by alpha, reduced by the low byte of the field polynomial.
  function automatic logic [7:0] gf_xtime(input logic [7:0] a, input logic [7:0] red);
    gf_xtime = a[7] ? ({a[6:0], 1'b0} ^ red) : {a[6:0], 1'b0};
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] red);
    logic [7:0] x;
    logic [7:0] acc;
    x   = a;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        acc = acc ^ x;
      end
      x = gf_xtime(x, red);
    end
    gf_mul = acc;
  endfunction

endpackage

FILE: rtl/core/rse_gen.sv
// ----------------------------------------------------------------------------
// rse_gen: configuration registers and generator derivation
// Holds the parity count and field polynomial and multiplies out
// g(x) = prod (x + alpha^i), one root per cycle, after each effective write.
// ----------------------------------------------------------------------------
module rse_gen import rse_pkg::*; #(
  parameter int unsigned MAX_PARITY = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CfgIdxW-1:0]            cfg_idx_i,
  input  logic [FpW-1:0]                cfg_data_i,
  output rse_ctrl_t                     ctrl_o,
  output logic [MAX_PARITY-1:0][7:0]    coeffs_o
);

  logic [PcW-1:0]                 pc_q, pc_d;
  logic [7:0]                     red_q, red_d;
  logic [MAX_PARITY-1:0][7:0]     poly_q, poly_d;
  logic [7:0]                     root_q, root_d;
  logic [PcW-1:0]                 step_q, step_d;
  logic                           busy_q, busy_d;
  logic                           wr_acc;
  logic                           wr_eff;

  assign cfg_ready_o = !busy_q;
  assign wr_acc      = cfg_valid_i && cfg_ready_o;

  // A parity count with low bits past MAX_PARITY is dropped without side effects.
  always_comb begin
    wr_eff = 1'b0;
    pc_d   = pc_q;
    red_d  = red_q;
    if (wr_acc) begin
      unique case (cfg_idx_i)
        CFG_PARITY_COUNT: begin
          if (cfg_data_i[PcW-1:0] <= PcW'(MAX_PARITY)) begin
            wr_eff = 1'b1;
            pc_d   = cfg_data_i[PcW-1:0];
          end
        end
        CFG_FIELD_POLY: begin
          wr_eff = 1'b1;
          red_d  = cfg_data_i[7:0];
        end
        default: wr_eff = 1'b0;
      endcase
    end
  end

  always_comb begin
    poly_d = poly_q;
    root_d = root_q;
    step_d = step_q;
    busy_d = busy_q;
    if (wr_eff) begin
      poly_d    = '0;
      poly_d[0] = 8'h01;
      root_d    = 8'h02;
      step_d    = '0;
      busy_d    = (pc_d != '0);
    end else if (busy_q) begin
      for (int k = 0; k < MAX_PARITY; k++) begin
        poly_d[k] = ((k == 0) ? 8'h00 : poly_q[k-1]) ^ gf_mul(root_q, poly_q[k], red_q);
      end
      root_d = gf_xtime(root_q, red_q);
      step_d = step_q + 1'b1;
      if (step_q + 1'b1 == pc_q) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      red_q  <= FIELD_POLY_RESET[7:0];
      poly_q <= '0;
      root_q <= 8'h02;
      step_q <= '0;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      red_q  <= red_d;
      poly_q <= poly_d;
      root_q <= root_d;
      step_q <= step_d;
      busy_q <= busy_d;
    end
  end

  assign ctrl_o.parity_count = pc_q;
  assign ctrl_o.red          = red_q;
  assign ctrl_o.clear        = wr_eff;
  assign ctrl_o.busy         = busy_q;
  assign coeffs_o            = poly_q;

  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (step_q < pc_q))
    else $error("generator step counter ran past the parity count");

endmodule

FILE: rtl/core/rse_front.sv
// ----------------------------------------------------------------------------
// rse_front: input acceptance and block classification
// Counts message bytes, tracks overlong blocks and tags each item with
// its fault state before it enters the queue.
// ----------------------------------------------------------------------------
module rse_front import rse_pkg::*; #(
  parameter int unsigned MAX_DATA = 255
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_i,
  input  rse_ctrl_t ctrl_i,
  input  logic      full_i,
  output logic      push_o,
  output q_entry_t  entry_o
);

  localparam int unsigned CntW = $clog2(MAX_DATA + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_DATA);

  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;
  logic            at_max;
  logic            ovf_now;

  assign in_ready_o = !full_i && !ctrl_i.busy;
  assign push_o     = in_valid_i && in_ready_o;

  assign at_max  = (count_q >= MaxCnt);
  assign ovf_now = ovf_q || at_max;

  assign entry_o.data  = in_i.data_byte;
  assign entry_o.last  = in_i.last_in;
  assign entry_o.fault = (ctrl_i.parity_count == '0) || ovf_now;

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (ctrl_i.clear) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end else if (push_o) begin
      if (in_i.last_in) begin
        count_d = '0;
        ovf_d   = 1'b0;
      end else begin
        count_d = at_max ? count_q : count_q + 1'b1;
        ovf_d   = ovf_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

FILE: rtl/core/rse_fifo.sv
// ----------------------------------------------------------------------------
// rse_fifo: two-entry queue between front and back
// Lets the front keep accepting bytes while the back streams parity.
// ----------------------------------------------------------------------------
module rse_fifo import rse_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output q_entry_t entry_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  q_entry_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !pop_i) |=> (cnt_q == CntW'(Depth)) && $stable(wr_ptr_q))
    else $error("queue written while full");

endmodule

FILE: rtl/core/rse_back.sv
// ----------------------------------------------------------------------------
// rse_back: division LFSR and result sequencer
// Passes message bytes through, advances the LFSR stages in use each byte and
// shifts the parity out, highest stage first, after a good block's last byte.
// ----------------------------------------------------------------------------
module rse_back import rse_pkg::*; #(
  parameter int unsigned MAX_PARITY = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rse_ctrl_t                  ctrl_i,
  input  logic [MAX_PARITY-1:0][7:0] coeffs_i,
  input  logic                       empty_i,
  input  q_entry_t                   entry_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output out_item_t                  out_o
);

  localparam int unsigned IdxW = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1;

  typedef enum logic [1:0] {
    BK_DATA   = 2'b01,
    BK_PARITY = 2'b10
  } back_state_e;

  back_state_e                state_q, state_d;
  logic [MAX_PARITY-1:0][7:0] stages_q, stages_d;
  logic [MAX_PARITY-1:0][7:0] adv;
  logic [MAX_PARITY-1:0][7:0] shifted;
  logic [PcW-1:0]             rem_q, rem_d;
  logic [PcW-1:0]             n_m1;
  logic [IdxW-1:0]            top_idx;
  logic [7:0]                 fb;
  logic                       load_ok;
  logic                       emit;
  logic                       out_valid_q, out_valid_d;
  out_item_t                  out_q, out_d;

  assign n_m1    = ctrl_i.parity_count - 1'b1;
  assign top_idx = n_m1[IdxW-1:0];
  assign fb      = entry_i.data ^ stages_q[top_idx];
  assign load_ok = !out_valid_q || out_ready_i;

  // Only the stages below the parity count take part; the rest stay zero.
  always_comb begin
    for (int j = 0; j < MAX_PARITY; j++) begin
      if (PcW'(j) < ctrl_i.parity_count) begin
        adv[j]     = ((j == 0) ? 8'h00 : stages_q[j-1]) ^ gf_mul(coeffs_i[j], fb, ctrl_i.red);
        shifted[j] = (j == 0) ? 8'h00 : stages_q[j-1];
      end else begin
        adv[j]     = stages_q[j];
        shifted[j] = stages_q[j];
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    stages_d = stages_q;
    rem_d    = rem_q;
    out_d    = out_q;
    pop_o    = 1'b0;
    emit     = 1'b0;
    unique case (state_q)
      BK_DATA: begin
        if (load_ok && !empty_i) begin
          pop_o           = 1'b1;
          emit            = 1'b1;
          out_d.out_byte  = entry_i.data;
          out_d.is_parity = 1'b0;
          out_d.last_out  = entry_i.last && entry_i.fault;
          out_d.fault     = entry_i.fault;
          if (ctrl_i.parity_count != '0) begin
            stages_d = adv;
          end
          if (entry_i.last) begin
            if (entry_i.fault) begin
              stages_d = '0;
            end else begin
              state_d = BK_PARITY;
              rem_d   = ctrl_i.parity_count;
            end
          end
        end
      end
      BK_PARITY: begin
        if (load_ok) begin
          emit            = 1'b1;
          out_d.out_byte  = stages_q[top_idx];
          out_d.is_parity = 1'b1;
          out_d.last_out  = (rem_q == PcW'(1));
          out_d.fault     = 1'b0;
          stages_d        = shifted;
          rem_d           = rem_q - 1'b1;
          if (rem_q == PcW'(1)) begin
            state_d = BK_DATA;
          end
        end
      end
      default: state_d = BK_DATA;
    endcase
    if (ctrl_i.clear) begin
      stages_d = '0;
      state_d  = BK_DATA;
    end
  end

  assign out_valid_d = emit || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_DATA;
      stages_q    <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stages_q    <= stages_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_PARITY) |-> (rem_q != '0))
    else $error("parity state entered with nothing left to send");

  a_lfsr_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_PARITY && emit && rem_q == PcW'(1)) |=> (stages_q == '0))
    else $error("LFSR not empty after the final parity item");

endmodule

FILE: rtl/core/rs_systematic_encoder_gf256.sv
// ----------------------------------------------------------------------------
// rs_systematic_encoder_gf256: systematic Reed-Solomon encoder, GF(256)
// Message bytes pass through and feed a division LFSR; parity follows the
// last byte of each good block.
// ----------------------------------------------------------------------------
// Message items are accepted one per cycle while the queue has room and the
// generator is idle; each leaves as one result item through the queue and
// the output register, and the LFSR stages in use update in parallel per
// byte. The last byte of a good block holds the back end while the parity is
// shifted out of the LFSR one byte per cycle whenever the output is taken;
// the two-entry queue between front and back takes up to two more bytes,
// and then the input stalls until the parity is out. After a write that sets
// a non-zero parity count, or changes the field polynomial while one is set,
// the generator is multiplied out one root per cycle, accepting neither items
// nor writes meanwhile. Results carry fault = 1 when the parity count is zero
// and beyond MAX_DATA bytes of a block; neither kind of block gets parity.
// ----------------------------------------------------------------------------
module rs_systematic_encoder_gf256 import rse_pkg::*; #(
  parameter int unsigned MAX_PARITY = 32,
  parameter int unsigned MAX_DATA   = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [FpW-1:0]     cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_o
);

  rse_ctrl_t                  ctrl;
  logic [MAX_PARITY-1:0][7:0] coeffs;
  logic                       q_full;
  logic                       q_empty;
  logic                       q_push;
  logic                       q_pop;
  q_entry_t                   q_wr_entry;
  q_entry_t                   q_rd_entry;

  rse_gen #(
    .MAX_PARITY (MAX_PARITY)
  ) u_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .ctrl_o      (ctrl),
    .coeffs_o    (coeffs)
  );

  rse_front #(
    .MAX_DATA (MAX_DATA)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .ctrl_i     (ctrl),
    .full_i     (q_full),
    .push_o     (q_push),
    .entry_o    (q_wr_entry)
  );

  rse_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .entry_o (q_rd_entry)
  );

  rse_back #(
    .MAX_PARITY (MAX_PARITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .coeffs_i    (coeffs),
    .empty_i     (q_empty),
    .entry_i     (q_rd_entry),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

FILE: bench/tb_rs_systematic_encoder_gf256.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rs_systematic_encoder_gf256: self-checking bench for the RS encoder
// A short table of directed items and register writes is followed by random
// blocks under random parity counts and field polynomials. Every result item
// is compared with the bench's behavioural encoder or a typed row's result.
// ----------------------------------------------------------------------------
module tb_rs_systematic_encoder_gf256;
  import rse_pkg::*;

  localparam int unsigned PARITY_MAX = 32;
  localparam int unsigned BLOCK_MAX  = 255;
  localparam int unsigned ROW_COUNT  = 28;
  localparam int unsigned RAND_ITEMS = 60;

  // Indexes with no register behind them.
  localparam logic [CfgIdxW-1:0] CFG_IDX_SPARE2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_IDX_SPARE3 = 2'd3;

  typedef enum logic {
    ROW_WRITE,
    ROW_BYTE
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] idx;
    logic [FpW-1:0]     wdata;
    in_item_t           item;
    logic               typed;
    out_item_t          want;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [ROW_COUNT] = '{
    '{ROW_BYTE,  CFG_PARITY_COUNT, 9'h000, '{8'h00, 1'b0}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1}},
    '{ROW_BYTE,  CFG_PARITY_COUNT, 9'h000, '{8'hff, 1'b1}, 1'b1, '{8'hff, 1'b0, 1'b1, 1'b1}},
    '{ROW_WRITE, CFG_PARITY_COUNT, 9'd32,  '{8'h00, 1'b0}, 1'b0, '0},
    '{ROW_BYTE,  CFG_PARITY_COUNT, 9'h000, '{8'hff, 1'b0}, 1'b0, '0},
    '{ROW_BYTE,  CFG_PARITY_COUNT, 9'h000, '{8'h00, 1'b0}, 1'b0, '0},
    '{ROW_BYTE,  CFG_PARITY_COUNT, 9'h000, '{8'ha5, 1'b1}, 1'b0, '0},
    '{ROW_WRITE, CFG_PARITY_COUNT, 9'd1,   '{8'h00, 1'b0}, 1'b0, '0},
    '{ROW_BYTE,  CFG_PARITY_COUNT, 9'h000, '{8'h80, 1'b1}, 1'b0, '0},
    '{ROW_WRITE, CFG_FIELD_POLY,   9'h1ff, '{8'h00, 1'b0}, 1'b0, '0},
    '{ROW_BYTE,  CFG_PARITY_COUNT, 9'h000, '{8'h5a, 1'b1}, 1'b0, '0},
    '{ROW_WRITE, CFG_FIELD_POLY,   9'h101, '{8'h00, 1'b0}, 1'b0, '0},
    '{ROW_BYTE,  CFG_PARITY_COUNT, 9'h000, '{8'h37, 1'b1}, 1'b0, '0},
    '{ROW_WRITE, CFG_FIELD_POLY,   9'h02b, '{8'h00, 1'b0}, 1'b0, '0},
    '{ROW_BYTE,  CFG_PARITY_COUNT, 9'h000, '{8'hc3, 1'b1}, 1'b0, '0},
    '{ROW_WRITE, CFG_PARITY_COUNT, 9'd40,  '{8'h00, 1'b0}, 1'b0, '0},
    '{ROW_BYTE,  CFG_PARITY_COUNT, 9'h000, '{8'h11, 1'b1}, 1'b0, '0},
    '{ROW_WRITE, CFG_IDX_SPARE2,   9'h1aa, '{8'h00, 1'b0}, 1'b0, '0},
    '{ROW_WRITE, CFG_IDX_SPARE3,   9'h055, '{8'h00, 1'b0}, 1'b0, '0},
    '{ROW_BYTE,  CFG_PARITY_COUNT, 9'h000, '{8'h6c, 1'b1}, 1'b0, '0},
    '{ROW_WRITE, CFG_FIELD_POLY,   9'h11d, '{8'h00, 1'b0}, 1'b0, '0},
    '{ROW_WRITE, CFG_PARITY_COUNT, 9'h110, '{8'h00, 1'b0}, 1'b0, '0},
    '{ROW_BYTE,  CFG_PARITY_COUNT, 9'h000, '{8'h12, 1'b0}, 1'b0, '0},
    '{ROW_WRITE, CFG_PARITY_COUNT, 9'd8,   '{8'h00, 1'b0}, 1'b0, '0},
    '{ROW_BYTE,  CFG_PARITY_COUNT, 9'h000, '{8'h34, 1'b0}, 1'b0, '0},
    '{ROW_BYTE,  CFG_PARITY_COUNT, 9'h000, '{8'h56, 1'b1}, 1'b0, '0},
    '{ROW_WRITE, CFG_PARITY_COUNT, 9'd0,   '{8'h00, 1'b0}, 1'b0, '0},
    '{ROW_BYTE,  CFG_PARITY_COUNT, 9'h000, '{8'h7e, 1'b1}, 1'b1, '{8'h7e, 1'b0, 1'b1, 1'b1}},
    '{ROW_BYTE,  CFG_PARITY_COUNT, 9'h000, '{8'h01, 1'b0}, 1'b1, '{8'h01, 1'b0, 1'b0, 1'b1}}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [FpW-1:0]     cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  in_item_t           in_i;
  logic               out_valid_o;
  logic               out_ready_i;
  out_item_t          out_o;

  rs_systematic_encoder_gf256 uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Behavioural copy of the encoder state.
  logic [PcW-1:0] enc_parity;
  logic [FpW-1:0] enc_poly;
  logic [7:0]     enc_lfsr [PARITY_MAX];
  logic [7:0]     enc_gen  [PARITY_MAX];
  int unsigned    enc_count;
  bit             enc_overflow;

  out_item_t codeword_q[$];
  out_item_t mon_want;

  bit gaps_on;
  int errors;
  int bytes_sent;
  int blocks_sent;
  int writes_done;
  int fault_blocks;
  int results_seen;
  int rand_items;

  // Horner form of the field product, reduced by the low byte of the polynomial.
  function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int k = 7; k >= 0; k--) begin
      acc = {acc[6:0], 1'b0} ^ (acc[7] ? enc_poly[7:0] : 8'h00);
      if (b[k]) begin
        acc = acc ^ a;
      end
    end
    return acc;
  endfunction

  task automatic build_generator();
    logic [7:0] poly [PARITY_MAX+1];
    logic [7:0] root;
    for (int k = 0; k <= PARITY_MAX; k++) begin
      poly[k] = 8'h00;
    end
    poly[0] = 8'h01;
    root    = 8'h01;
    for (int i = 1; i <= int'(enc_parity); i++) begin
      root = gf_times(root, 8'h02);
      for (int k = i; k > 0; k--) begin
        poly[k] = poly[k-1] ^ gf_times(root, poly[k]);
      end
      poly[0] = gf_times(root, poly[0]);
    end
    for (int k = 0; k < PARITY_MAX; k++) begin
      enc_gen[k] = (k < int'(enc_parity)) ? poly[k] : 8'h00;
    end
  endtask

  task automatic clear_block_state();
    for (int k = 0; k < PARITY_MAX; k++) begin
      enc_lfsr[k] = 8'h00;
    end
    enc_count    = 0;
    enc_overflow = 1'b0;
  endtask

  task automatic apply_reg(input logic [CfgIdxW-1:0] idx, input logic [FpW-1:0] wdata);
    bit taken;
    taken = 1'b0;
    if (idx == CFG_PARITY_COUNT) begin
      if (wdata[PcW-1:0] <= PARITY_MAX) begin
        enc_parity = wdata[PcW-1:0];
        taken      = 1'b1;
      end
    end else if (idx == CFG_FIELD_POLY) begin
      enc_poly = wdata;
      taken    = 1'b1;
    end
    if (taken) begin
      build_generator();
      clear_block_state();
    end
  endtask

  // Advances the encoder by one message byte and queues the results it causes.
  task automatic encode_byte(input in_item_t it);
    logic [7:0] fb;
    bit         flt;
    int         n;
    out_item_t  res;
    n = int'(enc_parity);
    if (enc_count >= BLOCK_MAX) begin
      enc_overflow = 1'b1;
    end else begin
      enc_count++;
    end
    if (n >= 1) begin
      fb = it.data_byte ^ enc_lfsr[n-1];
      for (int j = n - 1; j > 0; j--) begin
        enc_lfsr[j] = enc_lfsr[j-1] ^ gf_times(enc_gen[j], fb);
      end
      enc_lfsr[0] = gf_times(enc_gen[0], fb);
    end
    flt = (n == 0) || enc_overflow;
    res = '{it.data_byte, 1'b0, it.last_in && flt, flt};
    codeword_q.push_back(res);
    if (it.last_in) begin
      blocks_sent++;
      if (flt) begin
        fault_blocks++;
      end else begin
        for (int j = 0; j < n; j++) begin
          res = '{enc_lfsr[n-1-j], 1'b1, j == n - 1, 1'b0};
          codeword_q.push_back(res);
        end
      end
      clear_block_state();
    end
  endtask

  task automatic send_byte(input in_item_t it, input bit typed, input out_item_t want);
    while (gaps_on && $urandom_range(0, 99) < 10) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    encode_byte(it);
    // A typed row only ever causes one result, so it replaces the prediction.
    if (typed) begin
      codeword_q[codeword_q.size()-1] = want;
    end
    in_valid_i <= 1'b1;
    in_i       <= it;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [FpW-1:0] wdata);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (codeword_q.size() != 0);
    while (gaps_on && $urandom_range(0, 99) < 10) begin
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= wdata;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    apply_reg(idx, wdata);
    writes_done++;
  endtask

  task automatic send_block(input int len, input bit close);
    in_item_t it;
    for (int i = 0; i < len; i++) begin
      it.data_byte = 8'($urandom_range(0, 255));
      it.last_in   = close && (i == len - 1);
      send_byte(it, 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= !(gaps_on && $urandom_range(0, 99) < 10);
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      results_seen++;
      if (codeword_q.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: result item with nothing expected: byte %02h par %b last %b flt %b",
                   $realtime, out_o.out_byte, out_o.is_parity, out_o.last_out, out_o.fault);
        end
      end else begin
        mon_want = codeword_q.pop_front();
        if (out_o.out_byte !== mon_want.out_byte || out_o.is_parity !== mon_want.is_parity ||
            out_o.last_out !== mon_want.last_out || out_o.fault !== mon_want.fault) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: mismatch: byte %02h/%02h par %b/%b last %b/%b flt %b/%b (exp/act)",
                     $realtime, mon_want.out_byte, out_o.out_byte, mon_want.is_parity,
                     out_o.is_parity, mon_want.last_out, out_o.last_out, mon_want.fault,
                     out_o.fault);
          end
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [PcW-1:0] pc;
    logic [FpW-1:0] fp;
    int             pick;
    int             phase;
    gaps_on      = 1'b1;
    errors       = 0;
    bytes_sent   = 0;
    blocks_sent  = 0;
    writes_done  = 0;
    fault_blocks = 0;
    results_seen = 0;
    rand_items   = 0;
    enc_parity   = '0;
    enc_poly     = FIELD_POLY_RESET;
    build_generator();
    clear_block_state();

    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_idx_i   <= CFG_PARITY_COUNT;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    in_i        <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < ROW_COUNT; r++) begin
      if (DIR_ROWS[r].kind == ROW_WRITE) begin
        write_reg(DIR_ROWS[r].idx, DIR_ROWS[r].wdata);
      end else begin
        send_byte(DIR_ROWS[r].item, DIR_ROWS[r].typed, DIR_ROWS[r].want);
      end
    end

    phase = 0;
    while (rand_items < RAND_ITEMS) begin
      // The fourth phase, if reached, runs with no idling on either side.
      gaps_on = (phase != 3);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        pc = '0;
      end else if (pick == 1) begin
        pc = PcW'(PARITY_MAX);
      end else begin
        pc = PcW'($urandom_range(1, 16));
      end
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        fp = FIELD_POLY_RESET;
      end else if (pick < 8) begin
        fp = FpW'($urandom_range(257, 511));
      end else begin
        fp = FpW'($urandom_range(0, 511));
      end
      if ($urandom_range(0, 1) == 1) begin
        write_reg(CFG_FIELD_POLY, fp);
        write_reg(CFG_PARITY_COUNT, {3'($urandom_range(0, 7)), pc});
      end else begin
        write_reg(CFG_PARITY_COUNT, {3'($urandom_range(0, 7)), pc});
        write_reg(CFG_FIELD_POLY, fp);
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        write_reg(CFG_PARITY_COUNT, FpW'($urandom_range(33, 63)));
      end else if (pick == 1) begin
        write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE3 : CFG_IDX_SPARE2,
                  FpW'($urandom_range(0, 511)));
      end
      for (int b = $urandom_range(1, 4); b > 0; b--) begin
        pick = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        if ($urandom_range(0, 9) == 0) begin
          // A block cut short by a register write, which discards it.
          send_block(pick, 1'b0);
          write_reg(CFG_FIELD_POLY, enc_poly);
        end else begin
          send_block(pick, 1'b1);
        end
        rand_items += pick;
      end
      phase++;
    end

    // A block one byte beyond the length limit, sent without idling, then a
    // short block to show that the count starts again.
    write_reg(CFG_FIELD_POLY, FIELD_POLY_RESET);
    write_reg(CFG_PARITY_COUNT, PcW'($urandom_range(1, PARITY_MAX)));
    gaps_on = 1'b0;
    send_block(BLOCK_MAX + 1, 1'b1);
    gaps_on = 1'b1;
    send_block(5, 1'b1);

    in_valid_i <= 1'b0;
    for (int c = 0; c < 20000 && codeword_q.size() != 0; c++) begin
      @(posedge clk_i);
    end
    repeat (40) @(posedge clk_i);
    if (codeword_q.size() != 0) begin
      errors += codeword_q.size();
      $display("%0d expected result items never arrived", codeword_q.size());
    end

    $display("Sent %0d message bytes in %0d blocks with %0d register writes.",
             bytes_sent, blocks_sent, writes_done);
    $display("Checked %0d result items; %0d blocks faulted; %0d mismatches.",
             results_seen, fault_blocks, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/rse_pkg.sv
rtl/core/rse_gen.sv
rtl/core/rse_front.sv
rtl/core/rse_fifo.sv
rtl/core/rse_back.sv
rtl/core/rs_systematic_encoder_gf256.sv
bench/tb_rs_systematic_encoder_gf256.sv
